// ===== rtl/core/hpmc_pkg.sv =====
// Shared constants, types and helpers of the half-pel motion compensation unit.
package hpmc_pkg;

  localparam int LINE_STRIDE = 256;
  localparam int PLANE_ROWS  = 256;
  localparam int MAX_BLOCK   = 16;

  localparam int HALF_LINE = LINE_STRIDE / 2;
  localparam int COL_W     = $clog2(LINE_STRIDE);
  localparam int ROW_W     = $clog2(PLANE_ROWS);
  localparam int MEM_DEPTH = 2 * PLANE_ROWS;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int LINE_W    = LINE_STRIDE * 8;
  localparam int N_SMALL   = (MAX_BLOCK < 8) ? MAX_BLOCK : 8;
  localparam int N_LARGE   = (MAX_BLOCK < 16) ? MAX_BLOCK : 16;
  localparam int CW        = 14;
  localparam int PADDR_W   = 4;

  typedef enum logic [1:0] {
    REG_PICTURE_WIDTH    = 2'd0,
    REG_PICTURE_HEIGHT   = 2'd1,
    REG_ROUNDING_CONTROL = 2'd2,
    REG_NONE             = 2'd3
  } reg_index_t;

  typedef enum logic {
    MODE_WRITE   = 1'b0,
    MODE_PREDICT = 1'b1
  } mode_t;

  typedef logic signed [CW-1:0]         sv_t;
  typedef logic [LINE_STRIDE-1:0][7:0]  line_t;
  typedef logic [MAX_BLOCK:0][7:0]      pix_row_t;
  typedef logic [COL_W-1:0]             col_t;

  typedef struct packed {
    logic              mode;
    logic              plane;
    logic [7:0]        origin_row;
    logic [7:0]        origin_column;
    logic [7:0]        pixel_value;
    logic signed [11:0] mv_x;
    logic signed [11:0] mv_y;
    logic              large_block;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  row_index;
    logic [63:0] pixels_low;
    logic [63:0] pixels_high;
    logic        last_row;
  } out_item_t;

  typedef struct packed {
    logic fx;
    logic fy;
    logic rc;
    logic blk16;
  } filt_ctrl_t;

  // Upper bound first, then the lower bound of zero wins.
  function automatic sv_t clamp_hi(sv_t v, sv_t hi);
    sv_t r;
    r = v;
    if (r > hi) r = hi;
    if (r < 0) r = '0;
    return r;
  endfunction

endpackage

// ===== rtl/core/hpmc_ram.sv =====
// Generic single-port synchronous RAM with registered read.
module hpmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/core/hpmc_filter.sv =====
// Half-pel interpolation of one block row and the result register.
module hpmc_filter (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  valid,
  input  hpmc_pkg::filt_ctrl_t  ctrl,
  input  hpmc_pkg::pix_row_t    top,
  input  hpmc_pkg::pix_row_t    bot,
  input  logic [3:0]            row,
  input  logic                  last,
  output logic                  strobe,
  output hpmc_pkg::out_item_t   result
);

  logic [15:0][7:0] pix;

  always_comb begin
    logic [9:0] s;
    pix = '0;
    for (int x = 0; x < hpmc_pkg::MAX_BLOCK; x++) begin
      s = '0;
      unique case ({ctrl.fx, ctrl.fy})
        2'b00: s = {2'b00, top[x]};
        2'b10: s = 10'((11'(top[x]) + 11'(top[x+1]) + 11'd1 - 11'(ctrl.rc)) >> 1);
        2'b01: s = 10'((11'(top[x]) + 11'(bot[x]) + 11'd1 - 11'(ctrl.rc)) >> 1);
        2'b11: s = 10'((11'(top[x]) + 11'(top[x+1]) + 11'(bot[x]) + 11'(bot[x+1])
                       + 11'd2 - 11'(ctrl.rc)) >> 2);
        default: s = '0;
      endcase
      if (x < 8 || ctrl.blk16) pix[x] = s[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= valid;
    end
    if (valid) begin
      result.row_index   <= row;
      result.pixels_low  <= pix[7:0];
      result.pixels_high <= pix[15:8];
      result.last_row    <= last;
    end
  end

endmodule

// ===== rtl/core/half_pel_motion_compensation_unit.sv =====
// Top level of the half-pel motion compensation unit: control, store and APB registers.
// Usage notes
//  - Command channel: item is taken at a rising edge with start high and busy low.
//    A write item (mode 0) stores one reference pixel by read-modify-write of a
//    whole store line: busy in the read and modify states, no results.
//  - A predict item (mode 1) clamps 17 columns in the setup state, then reads one
//    clamped reference row per cycle from the line-wide store: n rows, or n+1 with
//    a vertical half-pel, n being 8 or 16.
//  - Each line read passes the store's read register, the byte-select register
//    and the filter's result register, which shows one block row per cycle on
//    result with result_strobe.
//  - busy stays high until the last line read is byte-selected; the store's
//    single port (one line a cycle) bounds the read rate.
//  - Results cannot be held off: each result row is valid for exactly one cycle.
//  - A new item may be taken while the last result row is still shown.
//  - Reset: synchronous, active high; registers return to width 256, height 192,
//    rounding control 0. The store is not cleared: entries are undefined until written.
//  - APB registers: 0x0 picture_width, 0x4 picture_height, 0x8 rounding_control;
//    pready is tied high, writes complete in the access phase.
module half_pel_motion_compensation_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  hpmc_pkg::in_item_t                item,
  output logic                              result_strobe,
  output hpmc_pkg::out_item_t               result,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hpmc_pkg::PADDR_W-1:0]      paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_WR_READ, ST_WR_MOD, ST_SETUP, ST_RUN
  } state_t;

  state_t state;

  // configuration
  logic [8:0] picture_width;
  logic [8:0] picture_height;
  logic       rounding_control;
  hpmc_pkg::reg_index_t reg_sel;

  // write item
  logic                        wplane;
  logic [hpmc_pkg::ROW_W-1:0]  wrow;
  hpmc_pkg::col_t              wcol;
  logic [7:0]                  wpix;

  // predict item
  logic                plane;
  logic                fx;
  logic                fy;
  logic                blk16;
  hpmc_pkg::sv_t       ix;
  hpmc_pkg::sv_t       iy;
  hpmc_pkg::sv_t       cpos;
  hpmc_pkg::sv_t       base;
  hpmc_pkg::sv_t       chi;
  hpmc_pkg::sv_t       rhi;
  hpmc_pkg::sv_t       orow;
  hpmc_pkg::col_t      cols [hpmc_pkg::MAX_BLOCK+1];
  logic [4:0]          nrows;
  logic [4:0]          nreads;
  logic [4:0]          rd_cnt;
  logic                rv;
  logic [4:0]          rk;
  logic                cv;
  logic [4:0]          ck;
  hpmc_pkg::pix_row_t  cur_pix;
  hpmc_pkg::pix_row_t  prev_pix;

  // store port
  logic                        ram_we;
  logic [hpmc_pkg::MEM_AW-1:0] ram_addr;
  hpmc_pkg::line_t             ram_wdata;
  hpmc_pkg::line_t             ram_rdata;
  logic                        issue;
  hpmc_pkg::sv_t               rd_row;

  // filter hookup
  hpmc_pkg::filt_ctrl_t fctrl;
  logic                 fvalid;
  logic [4:0]           frow;

  // decode of an accepted predict item
  hpmc_pkg::sv_t acc_ix;
  hpmc_pkg::sv_t acc_iy;
  hpmc_pkg::sv_t acc_cpos;
  hpmc_pkg::sv_t acc_base;
  hpmc_pkg::sv_t acc_chi;
  hpmc_pkg::sv_t acc_rhi;
  hpmc_pkg::sv_t lim;

  logic accept;
  logic cfg_write;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = hpmc_pkg::reg_index_t'(paddr[3:2]);

  always_comb begin
    unique case (reg_sel)
      hpmc_pkg::REG_PICTURE_WIDTH:    prdata = {23'd0, picture_width};
      hpmc_pkg::REG_PICTURE_HEIGHT:   prdata = {23'd0, picture_height};
      hpmc_pkg::REG_ROUNDING_CONTROL: prdata = {31'd0, rounding_control};
      default:                        prdata = '0;
    endcase
  end

  // floor split of the vector; chroma selects a sub-plane by the column's half
  always_comb begin
    acc_ix = hpmc_pkg::sv_t'(item.mv_x) >>> 1;
    acc_iy = hpmc_pkg::sv_t'(item.mv_y) >>> 1;
    if (!item.plane) begin
      acc_base = '0;
      acc_cpos = hpmc_pkg::sv_t'({1'b0, item.origin_column});
      acc_chi  = hpmc_pkg::sv_t'({1'b0, picture_width}) - hpmc_pkg::sv_t'(1);
      lim      = hpmc_pkg::sv_t'(hpmc_pkg::LINE_STRIDE - 1);
      acc_rhi  = hpmc_pkg::sv_t'({1'b0, picture_height}) - hpmc_pkg::sv_t'(1);
    end else begin
      acc_base = (((item.origin_column / hpmc_pkg::HALF_LINE) & 8'd1) != 8'd0)
                 ? hpmc_pkg::sv_t'(hpmc_pkg::HALF_LINE) : '0;
      acc_cpos = hpmc_pkg::sv_t'({1'b0, item.origin_column % hpmc_pkg::HALF_LINE});
      acc_chi  = hpmc_pkg::sv_t'({2'b0, picture_width[8:1]}) - hpmc_pkg::sv_t'(1);
      lim      = hpmc_pkg::sv_t'(hpmc_pkg::HALF_LINE - 1);
      acc_rhi  = hpmc_pkg::sv_t'({2'b0, picture_height[8:1]}) - hpmc_pkg::sv_t'(1);
    end
    if (acc_chi > lim) acc_chi = lim;
    if (acc_rhi > hpmc_pkg::sv_t'(hpmc_pkg::PLANE_ROWS - 1)) begin
      acc_rhi = hpmc_pkg::sv_t'(hpmc_pkg::PLANE_ROWS - 1);
    end
  end

  // store access: line reads for prediction, read-modify-write for pixel writes
  always_comb begin
    issue  = (state == ST_RUN) && (rd_cnt < nreads);
    rd_row = hpmc_pkg::clamp_hi(orow + iy + hpmc_pkg::sv_t'({1'b0, rd_cnt}), rhi);
    ram_we = (state == ST_WR_MOD);
    if (state == ST_RUN) begin
      ram_addr = {plane, rd_row[hpmc_pkg::ROW_W-1:0]};
    end else begin
      ram_addr = {wplane, wrow};
    end
    ram_wdata       = ram_rdata;
    ram_wdata[wcol] = wpix;
  end

  hpmc_ram #(
    .WIDTH (hpmc_pkg::LINE_W),
    .DEPTH (hpmc_pkg::MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      picture_width    <= 9'd256;
      picture_height   <= 9'd192;
      rounding_control <= 1'b0;
      rd_cnt           <= '0;
      rv               <= 1'b0;
      cv               <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (reg_sel)
          hpmc_pkg::REG_PICTURE_WIDTH:    picture_width    <= pwdata[8:0];
          hpmc_pkg::REG_PICTURE_HEIGHT:   picture_height   <= pwdata[8:0];
          hpmc_pkg::REG_ROUNDING_CONTROL: rounding_control <= pwdata[0];
          default: ;
        endcase
      end
      // read pipeline: line data, then byte select, then filter
      rv <= issue;
      rk <= rd_cnt;
      cv <= rv;
      ck <= rk;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (item.mode == hpmc_pkg::MODE_PREDICT) begin
              state <= ST_SETUP;
            end else if (int'(item.origin_row) < hpmc_pkg::PLANE_ROWS &&
                         int'(item.origin_column) < hpmc_pkg::LINE_STRIDE) begin
              state <= ST_WR_READ;
            end
          end
        end
        ST_WR_READ: state <= ST_WR_MOD;
        ST_WR_MOD:  state <= ST_IDLE;
        ST_SETUP: begin
          state  <= ST_RUN;
          rd_cnt <= '0;
        end
        ST_RUN: begin
          if (issue) rd_cnt <= rd_cnt + 5'd1;
          if (cv && ck == nreads - 5'd1) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end

    // payload
    if (accept) begin
      wplane <= item.plane;
      wrow   <= hpmc_pkg::ROW_W'(item.origin_row);
      wcol   <= hpmc_pkg::COL_W'(item.origin_column);
      wpix   <= item.pixel_value;
      plane  <= item.plane;
      fx     <= item.mv_x[0];
      fy     <= item.mv_y[0];
      blk16  <= item.large_block;
      ix     <= acc_ix;
      iy     <= acc_iy;
      cpos   <= acc_cpos;
      base   <= acc_base;
      chi    <= acc_chi;
      rhi    <= acc_rhi;
      orow   <= hpmc_pkg::sv_t'({1'b0, item.origin_row});
      nrows  <= item.large_block ? 5'(hpmc_pkg::N_LARGE) : 5'(hpmc_pkg::N_SMALL);
      nreads <= (item.large_block ? 5'(hpmc_pkg::N_LARGE) : 5'(hpmc_pkg::N_SMALL))
                + 5'(item.mv_y[0]);
    end
    if (state == ST_SETUP) begin
      for (int x = 0; x <= hpmc_pkg::MAX_BLOCK; x++) begin
        cols[x] <= hpmc_pkg::COL_W'(base + hpmc_pkg::clamp_hi(
                     cpos + ix + hpmc_pkg::sv_t'(x), chi));
      end
    end
    if (rv) begin
      for (int x = 0; x <= hpmc_pkg::MAX_BLOCK; x++) begin
        cur_pix[x] <= ram_rdata[cols[x]];
      end
    end
    if (cv) prev_pix <= cur_pix;
  end

  // with a vertical half-pel the first line only primes the previous row
  always_comb begin
    fctrl.fx    = fx;
    fctrl.fy    = fy;
    fctrl.rc    = rounding_control;
    fctrl.blk16 = blk16;
    fvalid      = cv && !(fy && ck == 5'd0);
    frow        = fy ? ck - 5'd1 : ck;
  end

  hpmc_filter u_filter (
    .clk    (clk),
    .rst    (rst),
    .valid  (fvalid),
    .ctrl   (fctrl),
    .top    (fy ? prev_pix : cur_pix),
    .bot    (cur_pix),
    .row    (frow[3:0]),
    .last   (frow == nrows - 5'd1),
    .strobe (result_strobe),
    .result (result)
  );

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench of the half-pel motion compensation unit.
`timescale 1ns / 1ps

module tb;

  localparam int PLANE_BYTES = hpmc_pkg::PLANE_ROWS * hpmc_pkg::LINE_STRIDE;
  localparam int SETTLE      = 30;   // cycles after the last row before idle

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  hpmc_pkg::in_item_t    item;
  logic                  result_strobe;
  hpmc_pkg::out_item_t   result;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [hpmc_pkg::PADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  // local copy of the picture store and of the registers
  logic [7:0]  shadow_pix [0:2*PLANE_BYTES-1];
  bit          shadow_set [0:2*PLANE_BYTES-1];
  int          pic_w;
  int          pic_h;
  int          round_ctl;

  hpmc_pkg::out_item_t rows_due[$];
  int          fail_count;
  bit          gaps_on;

  half_pel_motion_compensation_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_strobe(result_strobe), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  function automatic int clip(int v, int lo, int hi);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v;
  endfunction

  function automatic int ref_byte(int plane, int r, int c);
    if (r < 0 || c < 0 || r >= hpmc_pkg::PLANE_ROWS || c >= hpmc_pkg::LINE_STRIDE) return 0;
    return shadow_pix[plane*PLANE_BYTES + r*hpmc_pkg::LINE_STRIDE + c];
  endfunction

  // Block size, vector split and clamp bounds of a predict item.
  task automatic block_geometry(input hpmc_pkg::in_item_t it, output int n,
                                output int fx, output int fy, output int ix,
                                output int iy, output int base, output int cpos,
                                output int chi, output int rhi);
    int mvx, mvy;
    n = it.large_block ? hpmc_pkg::N_LARGE : hpmc_pkg::N_SMALL;
    mvx = int'(it.mv_x);
    mvy = int'(it.mv_y);
    fx = mvx & 1;
    fy = mvy & 1;
    ix = (mvx - fx) / 2;
    iy = (mvy - fy) / 2;
    if (it.plane == 1'b0) begin
      base = 0;
      cpos = it.origin_column;
      chi = pic_w - 1;
      if (chi > hpmc_pkg::LINE_STRIDE - 1) chi = hpmc_pkg::LINE_STRIDE - 1;
      rhi = pic_h - 1;
    end else begin
      // chroma: upper half of the line is the second sub-plane
      base = ((int'(it.origin_column) / hpmc_pkg::HALF_LINE) & 1) * hpmc_pkg::HALF_LINE;
      cpos = int'(it.origin_column) % hpmc_pkg::HALF_LINE;
      chi = (pic_w >> 1) - 1;
      if (chi > hpmc_pkg::HALF_LINE - 1) chi = hpmc_pkg::HALF_LINE - 1;
      rhi = (pic_h >> 1) - 1;
    end
    if (rhi > hpmc_pkg::PLANE_ROWS - 1) rhi = hpmc_pkg::PLANE_ROWS - 1;
  endtask

  // Expected rows of a predict item, pushed in order onto rows_due.
  task automatic predict_block(hpmc_pkg::in_item_t it);
    int cols [0:hpmc_pkg::MAX_BLOCK];
    int n, fx, fy, ix, iy, base, cpos, chi, rhi, x, y, r0, r1;
    int a, b, c, d, p, pl;
    hpmc_pkg::out_item_t row;
    block_geometry(it, n, fx, fy, ix, iy, base, cpos, chi, rhi);
    pl = it.plane;
    for (x = 0; x <= n; x++) cols[x] = base + clip(cpos + x + ix, 0, chi);
    for (y = 0; y < n; y++) begin
      r0 = clip(int'(it.origin_row) + y + iy, 0, rhi);
      r1 = clip(int'(it.origin_row) + y + iy + fy, 0, rhi);
      row = '0;
      for (x = 0; x < n; x++) begin
        a = ref_byte(pl, r0, cols[x]);
        b = ref_byte(pl, r0, cols[x+1]);
        c = ref_byte(pl, r1, cols[x]);
        d = ref_byte(pl, r1, cols[x+1]);
        if (!fx && !fy) p = a;
        else if (fx && !fy) p = (a + b + 1 - round_ctl) >> 1;
        else if (!fx && fy) p = (a + c + 1 - round_ctl) >> 1;
        else p = (a + b + c + d + 2 - round_ctl) >> 2;
        if (x < 8) row.pixels_low[8*x +: 8] = p[7:0];
        else row.pixels_high[8*(x-8) +: 8] = p[7:0];
      end
      row.row_index = y[3:0];
      row.last_row = (y == n - 1);
      rows_due.push_back(row);
    end
  endtask

  // One item on the command port; the expectation is formed at acceptance.
  task automatic send_item(hpmc_pkg::in_item_t it);
    int k;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      k = $urandom_range(1, 5);
      repeat (k) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
    @(negedge clk);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    if (it.mode == hpmc_pkg::MODE_WRITE) begin
      shadow_pix[it.plane*PLANE_BYTES + it.origin_row*hpmc_pkg::LINE_STRIDE
                 + it.origin_column] = it.pixel_value;
      shadow_set[it.plane*PLANE_BYTES + it.origin_row*hpmc_pkg::LINE_STRIDE
                 + it.origin_column] = 1'b1;
    end else begin
      predict_block(it);
    end
  endtask

  task automatic write_pixel(int plane, int r, int c, int v);
    hpmc_pkg::in_item_t it;
    it = '0;
    it.mode = hpmc_pkg::MODE_WRITE;
    it.plane = plane[0];
    it.origin_row = r[7:0];
    it.origin_column = c[7:0];
    it.pixel_value = v[7:0];
    it.mv_x = 12'($urandom);
    it.mv_y = 12'($urandom);
    it.large_block = 1'($urandom_range(0, 1));
    send_item(it);
  endtask

  // Write every entry that a predict item reads and that holds nothing yet.
  task automatic prime_block(hpmc_pkg::in_item_t it);
    int n, fx, fy, ix, iy, base, cpos, chi, rhi, k, x, r, c, pl;
    block_geometry(it, n, fx, fy, ix, iy, base, cpos, chi, rhi);
    pl = it.plane;
    for (k = 0; k < n + fy; k++) begin
      r = clip(int'(it.origin_row) + iy + k, 0, rhi);
      for (x = 0; x <= n; x++) begin
        c = base + clip(cpos + x + ix, 0, chi);
        if (!shadow_set[pl*PLANE_BYTES + r*hpmc_pkg::LINE_STRIDE + c])
          write_pixel(pl, r, c, $urandom_range(0, 255));
      end
    end
  endtask

  task automatic predict(int plane, int r, int c, int mvx, int mvy, bit big);
    hpmc_pkg::in_item_t it;
    it.mode = hpmc_pkg::MODE_PREDICT;
    it.plane = plane[0];
    it.origin_row = r[7:0];
    it.origin_column = c[7:0];
    it.pixel_value = 8'($urandom);
    it.mv_x = mvx[11:0];
    it.mv_y = mvy[11:0];
    it.large_block = big;
    prime_block(it);
    send_item(it);
  endtask

  // Drain: every row in, then time for any write still in flight.
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (rows_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(hpmc_pkg::reg_index_t idx, int value);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= hpmc_pkg::PADDR_W'(4 * int'(idx));
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      hpmc_pkg::REG_PICTURE_WIDTH:    pic_w = value & 9'h1FF;
      hpmc_pkg::REG_PICTURE_HEIGHT:   pic_h = value & 9'h1FF;
      hpmc_pkg::REG_ROUNDING_CONTROL: round_ctl = value & 1;
      default: ;
    endcase
  endtask

  task automatic set_picture(int w, int h, int rc);
    wait_idle();
    reg_write(hpmc_pkg::REG_PICTURE_WIDTH, w);
    reg_write(hpmc_pkg::REG_PICTURE_HEIGHT, h);
    reg_write(hpmc_pkg::REG_ROUNDING_CONTROL, rc);
  endtask

  task automatic random_predict(bit big);
    predict($urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 255),
            $urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048, big);
  endtask

  // copy, both two-tap averages and the four-tap, both sizes, both planes
  task automatic test_filters();
    set_picture(6, 4, 0);
    predict(0, 0, 0, 0, 0, 0);
    predict(0, 2, 3, 1, 0, 1);
    predict(0, 4, 1, 0, 1, 0);
    predict(0, 1, 5, 3, -3, 1);
    predict(1, 0, 0, 1, 1, 0);
    predict(1, 3, 130, -1, 2, 0);
    predict(1, 2, 255, 1, 1, 1);
    set_picture(6, 4, 1);
    predict(0, 0, 0, 1, 1, 1);
    predict(0, 7, 9, 1, 0, 0);
    predict(1, 1, 129, 0, 1, 1);
  endtask

  // vectors and origins at their limits; blocks far outside the picture
  task automatic test_edges();
    predict(0, 255, 255, 2047, 2047, 1);
    predict(0, 0, 0, -2048, -2048, 1);
    predict(0, 255, 0, -1, 2047, 0);
    predict(0, 200, 200, 0, 0, 1);
    predict(1, 255, 127, 2047, -2048, 1);
    predict(1, 255, 128, -2048, 2047, 0);
  endtask

  // zero and one pixel pictures, and sizes at the top of the register range
  task automatic test_sizes();
    set_picture(0, 0, 0);
    predict(0, 5, 5, 1, 1, 1);
    predict(1, 5, 200, 1, 1, 0);
    set_picture(1, 1, 1);
    predict(0, 3, 3, 3, 3, 0);
    predict(1, 3, 3, 1, 1, 1);
    set_picture(511, 2, 0);
    predict(0, 0, 240, 17, 1, 1);
    predict(1, 1, 250, 13, 1, 1);
    set_picture(3, 511, 1);
    predict(0, 245, 0, 1, 23, 1);
    predict(1, 120, 128, 1, 9, 1);
  endtask

  task automatic test_random();
    int phase, i;
    for (phase = 0; phase < 4; phase++) begin
      set_picture($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(0, 1));
      if (phase == 3) gaps_on = 1'b0;   // run the tail back to back
      for (i = 0; i < 32; i++) begin
        if ($urandom_range(0, 9) < 3)
          write_pixel($urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255));
        else
          random_predict($urandom_range(0, 3) == 0);
      end
    end
  endtask

  // result rows: sampled at the edge that ends their cycle
  always @(posedge clk) begin
    if (!rst && result_strobe) begin
      if (rows_due.size() == 0) begin
        $display("%0t: unexpected row, actual %h", $time, result);
        fail_count++;
      end else begin
        if (result.row_index !== rows_due[0].row_index) begin
          $display("%0t: row_index expected %h actual %h", $time,
                   rows_due[0].row_index, result.row_index);
          fail_count++;
        end
        if (result.pixels_low !== rows_due[0].pixels_low) begin
          $display("%0t: pixels_low expected %h actual %h", $time,
                   rows_due[0].pixels_low, result.pixels_low);
          fail_count++;
        end
        if (result.pixels_high !== rows_due[0].pixels_high) begin
          $display("%0t: pixels_high expected %h actual %h", $time,
                   rows_due[0].pixels_high, result.pixels_high);
          fail_count++;
        end
        if (result.last_row !== rows_due[0].last_row) begin
          $display("%0t: last_row expected %b actual %b", $time,
                   rows_due[0].last_row, result.last_row);
          fail_count++;
        end
        void'(rows_due.pop_front());
      end
    end
  end

  initial begin
    rst = 1'b1; start = 1'b0; item = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    fail_count = 0; gaps_on = 1'b1;
    pic_w = 256; pic_h = 192; round_ctl = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_filters();
    test_edges();
    test_sizes();
    test_random();
    wait_idle();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
